/* rtl/core/ckb_pkg.sv */
// Shared types, constants and helpers for the color key sprite blitter.
// Used by every module of the block; depends on nothing.
package ckb_pkg;

   localparam int PIXEL_W     = 32;
   localparam int FB_INDEX_W  = 22;
   localparam int RGB_W       = 24;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int SIZE_W      = 13;   // clamped sizes, up to 4095
   localparam int CALC_W      = 16;   // signed clipping arithmetic

   localparam logic [PIXEL_W-1:0] RST_KEY_COLOR = 32'h0000_0000;

   localparam logic [11:0]        RST_SCREEN_WIDTH  = 12'd1024;
   localparam logic [11:0]        RST_SCREEN_HEIGHT = 12'd768;
   localparam logic signed [12:0] RST_PLACE_X       = 13'sd0;
   localparam logic signed [12:0] RST_PLACE_Y       = 13'sd0;
   localparam logic [10:0]        RST_SPRITE_COLS   = 11'd16;
   localparam logic [10:0]        RST_SPRITE_ROWS   = 11'd16;

   typedef enum logic [2:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_PLACE_X       = 3'd2,
      REG_PLACE_Y       = 3'd3,
      REG_SPRITE_COLS   = 3'd4,
      REG_SPRITE_ROWS   = 3'd5,
      REG_KEY_COLOR     = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [11:0]        screen_width;
      logic [11:0]        screen_height;
      logic signed [12:0] place_x;
      logic signed [12:0] place_y;
      logic [10:0]        sprite_cols;
      logic [10:0]        sprite_rows;
      logic [31:0]        key_color;
   } ckb_cfg_type;

   // Map zero to one and cap at maxv.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [11:0] v,
                                                     input int unsigned maxv);
      logic [SIZE_W-1:0] cap;
      cap = SIZE_W'(maxv);
      if (v == 12'd0) begin
         return SIZE_W'(1);
      end else if ({1'b0, v} > cap) begin
         return cap;
      end else begin
         return {1'b0, v};
      end
   endfunction

endpackage

/* rtl/core/ckb_csr.sv */
// Configuration register file behind the APB-style port.
// Uses ckb_pkg for the register map and the configuration struct.
module ckb_csr
   import ckb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output ckb_cfg_type           cfg
);

   ckb_cfg_type cfg_ff;
   ckb_cfg_type cfg_in;
   logic        wr_en;
   csr_reg_type sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign sel        = csr_reg_type'(csr_paddr[4:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[11:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[11:0];
            REG_PLACE_X:       cfg_in.place_x       = $signed(csr_pwdata[12:0]);
            REG_PLACE_Y:       cfg_in.place_y       = $signed(csr_pwdata[12:0]);
            REG_SPRITE_COLS:   cfg_in.sprite_cols   = csr_pwdata[10:0];
            REG_SPRITE_ROWS:   cfg_in.sprite_rows   = csr_pwdata[10:0];
            REG_KEY_COLOR:     cfg_in.key_color     = csr_pwdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_SCREEN_WIDTH:  csr_prdata = {20'd0, cfg_ff.screen_width};
         REG_SCREEN_HEIGHT: csr_prdata = {20'd0, cfg_ff.screen_height};
         REG_PLACE_X:       csr_prdata = {19'd0, cfg_ff.place_x};
         REG_PLACE_Y:       csr_prdata = {19'd0, cfg_ff.place_y};
         REG_SPRITE_COLS:   csr_prdata = {21'd0, cfg_ff.sprite_cols};
         REG_SPRITE_ROWS:   csr_prdata = {21'd0, cfg_ff.sprite_rows};
         REG_KEY_COLOR:     csr_prdata = cfg_ff.key_color;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.place_x       <= RST_PLACE_X;
         cfg_ff.place_y       <= RST_PLACE_Y;
         cfg_ff.sprite_cols   <= RST_SPRITE_COLS;
         cfg_ff.sprite_rows   <= RST_SPRITE_ROWS;
         cfg_ff.key_color     <= RST_KEY_COLOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/ckb_walk.sv */
// Raster position counters and the input register of the pixel pipeline.
// Uses ckb_pkg for the configuration struct and the size clamp.
module ckb_walk
   import ckb_pkg::*;
#(
   parameter int SPRITE_MAX = 1024
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  ckb_cfg_type                   cfg,
   input  logic                          load,
   input  logic                          drain,
   input  logic [PIXEL_W-1:0]            pixel,
   output logic                          s1_valid,
   output logic [PIXEL_W-1:0]            s1_pixel,
   output logic [$clog2(SPRITE_MAX)-1:0] s1_col,
   output logic [$clog2(SPRITE_MAX)-1:0] s1_row
);

   localparam int CNT_W = $clog2(SPRITE_MAX);

   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] pix_ff;
   logic [CNT_W-1:0]   col_s_ff;
   logic [CNT_W-1:0]   row_s_ff;
   logic [SIZE_W-1:0]  cols, rows;
   logic [SIZE_W-1:0]  col_next, row_next;

   assign cols     = clamp_size({1'b0, cfg.sprite_cols}, SPRITE_MAX);
   assign rows     = clamp_size({1'b0, cfg.sprite_rows}, SPRITE_MAX);
   assign col_next = SIZE_W'(col_ff) + SIZE_W'(1);
   assign row_next = SIZE_W'(row_ff) + SIZE_W'(1);

   // Advance column, wrap into the next row, wrap the row at sprite end.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (load) begin
         if (col_next >= cols) begin
            col_in = '0;
            row_in = (row_next >= rows) ? '0 : CNT_W'(row_next);
         end else begin
            col_in = CNT_W'(col_next);
         end
      end
   end

   always_comb begin
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (drain) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture the beat together with its raster position.
   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff   <= pixel;
         col_s_ff <= col_ff;
         row_s_ff <= row_ff;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_pixel = pix_ff;
   assign s1_col   = col_s_ff;
   assign s1_row   = row_s_ff;

endmodule

/* rtl/core/ckb_clip.sv */
// Clipping, color key test and framebuffer index, feeding the result register.
// Uses ckb_pkg for the configuration struct, widths and the size clamp.
module ckb_clip
   import ckb_pkg::*;
#(
   parameter int SCREEN_MAX = 2048,
   parameter int SPRITE_MAX = 1024
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  ckb_cfg_type                   cfg,
   input  logic                          s1_valid,
   input  logic [PIXEL_W-1:0]            s1_pixel,
   input  logic [$clog2(SPRITE_MAX)-1:0] s1_col,
   input  logic [$clog2(SPRITE_MAX)-1:0] s1_row,
   input  logic                          out_ready,
   output logic                          out_adv,
   output logic                          out_valid,
   output logic [FB_INDEX_W-1:0]         out_index,
   output logic [RGB_W-1:0]              out_rgb
);

   localparam int CNT_W = $clog2(SPRITE_MAX);

   logic [SIZE_W-1:0]        w, h, cols, rows;
   logic signed [CALC_W-1:0] x, y, ws, hs, cs_max, rs_max;
   logic signed [CALC_W-1:0] cs, rs, line, lo, span, span_l, scol;
   logic                     off_screen, hit;
   logic [SIZE_W+11:0]       prod;
   logic [FB_INDEX_W-1:0]    index;

   logic                     valid_ff, valid_in;
   logic [FB_INDEX_W-1:0]    index_ff;
   logic [RGB_W-1:0]         rgb_ff;

   assign w    = clamp_size(cfg.screen_width, SCREEN_MAX);
   assign h    = clamp_size(cfg.screen_height, SCREEN_MAX);
   assign cols = clamp_size({1'b0, cfg.sprite_cols}, SPRITE_MAX);
   assign rows = clamp_size({1'b0, cfg.sprite_rows}, SPRITE_MAX);

   assign x      = $signed({{(CALC_W-13){cfg.place_x[12]}}, cfg.place_x});
   assign y      = $signed({{(CALC_W-13){cfg.place_y[12]}}, cfg.place_y});
   assign ws     = $signed({{(CALC_W-SIZE_W){1'b0}}, w});
   assign hs     = $signed({{(CALC_W-SIZE_W){1'b0}}, h});
   assign cs_max = $signed({{(CALC_W-SIZE_W){1'b0}}, cols});
   assign rs_max = $signed({{(CALC_W-SIZE_W){1'b0}}, rows});
   assign cs     = $signed({{(CALC_W-CNT_W){1'b0}}, s1_col});
   assign rs     = $signed({{(CALC_W-CNT_W){1'b0}}, s1_row});

   assign off_screen = (x + cs_max < 0) || (x > ws) || (y + rs_max < 0) || (y > hs);
   assign line       = y + rs;
   assign scol       = x + cs;
   assign span_l     = cs_max + x;

   // Horizontal span: left edge clip when placed left of the screen, else right clip.
   always_comb begin
      if (x < 0) begin
         lo   = -x;
         span = (span_l > ws) ? ws : span_l;
      end else begin
         lo   = '0;
         span = (x + cs_max >= ws) ? (ws - x) : cs_max;
      end
   end

   assign hit = !off_screen && (line >= 0) && (line < hs) && (cs >= lo)
                && (cs < lo + span) && (s1_pixel != cfg.key_color);

   assign prod  = line[11:0] * w;
   assign index = FB_INDEX_W'(prod) + FB_INDEX_W'(scol[CALC_W-1:0]);

   // Hold a stalled result; take the next one as soon as the slot frees.
   assign out_adv  = !valid_ff || out_ready;
   assign valid_in = out_adv ? (s1_valid && hit) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_valid && hit) begin
         index_ff <= index;
         rgb_ff   <= s1_pixel[RGB_W-1:0];
      end
   end

   assign out_valid = valid_ff;
   assign out_index = index_ff;
   assign out_rgb   = rgb_ff;

endmodule

/* rtl/core/color_key_sprite_blitter.sv */
// Color key sprite blitter: takes one 32-bit sprite pixel per beat in raster
// order, tracks the sprite column and row, clips against the screen and drops
// pixels equal to the key color; each surviving pixel leaves as one beat with
// its framebuffer index and 24-bit color. Throughput is one pixel per clock
// while the result beat is not stalled; the input register holds the pixel
// during one stage of clip compare and the row-times-width multiply, and the
// result register presents the beat. Clipped or keyed pixels produce no beat.
// Depends on ckb_pkg, ckb_csr, ckb_walk and ckb_clip.
module color_key_sprite_blitter
   import ckb_pkg::*;
#(
   parameter int SCREEN_MAX = 2048,
   parameter int SPRITE_MAX = 1024
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,   // [31:0] pixel_word
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [21:0] fb_index, [45:22] rgb, [47:46] zero
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(SPRITE_MAX);

   ckb_cfg_type           cfg;
   logic                  load;
   logic                  out_adv;
   logic                  s1_valid;
   logic [PIXEL_W-1:0]    s1_pixel;
   logic [CNT_W-1:0]      s1_col;
   logic [CNT_W-1:0]      s1_row;
   logic [FB_INDEX_W-1:0] fb_index;
   logic [RGB_W-1:0]      rgb;

   assign req_tready = !s1_valid || out_adv;
   assign load       = req_tvalid && req_tready;
   assign rsp_tdata  = {2'b00, rgb, fb_index};

   ckb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ckb_walk #(
      .SPRITE_MAX (SPRITE_MAX)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .load     (load),
      .drain    (out_adv),
      .pixel    (req_tdata),
      .s1_valid (s1_valid),
      .s1_pixel (s1_pixel),
      .s1_col   (s1_col),
      .s1_row   (s1_row)
   );

   ckb_clip #(
      .SCREEN_MAX (SCREEN_MAX),
      .SPRITE_MAX (SPRITE_MAX)
   ) u_clip (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .s1_valid  (s1_valid),
      .s1_pixel  (s1_pixel),
      .s1_col    (s1_col),
      .s1_row    (s1_row),
      .out_ready (rsp_tready),
      .out_adv   (out_adv),
      .out_valid (rsp_tvalid),
      .out_index (fb_index),
      .out_rgb   (rgb)
   );

endmodule

/* rtl/core/ckb_checker.sv */
// Port-level checks for the color key sprite blitter, bound to the top level.
// Uses ckb_pkg for port widths.
module ckb_checker
   import ckb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_pready
);

   // A stalled result beat keeps its valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its data.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   // A fresh result comes from a pixel taken into the input register, then passed to the result register.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result beat without a matching input beat");

   // Reset empties the result register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The configuration port never waits.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port not ready");

endmodule

bind color_key_sprite_blitter ckb_checker u_ckb_checker (.*);
